/* rtl/wav_stream_to_pcm16_top_assert.svh */
// assertion macros for the wav stream to pcm16 block
`ifndef WAV_STREAM_TO_PCM16_TOP_ASSERT_SVH
`define WAV_STREAM_TO_PCM16_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define WSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define WSP_ASSERT(lbl, clk, rstn, prop, msg)
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/wsp_pkg.sv */
// package for the wav stream to pcm16 block
`timescale 1ns / 1ps
package wsp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_CHDR = 3'd1,
    PH_BODY = 3'd2,
    PH_PAD  = 3'd3,
    PH_IDLE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SMALL     = 3'd1,
    ST_NOT_RIFF  = 3'd2,
    ST_NO_FMT    = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_BAD_FMT   = 3'd5,
    ST_BAD_PCM   = 3'd6,
    ST_BAD_FLOAT = 3'd7
  } status_e;

  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [15:0] FmtPcm  = 16'd1;
  localparam logic [15:0] FmtFlt  = 16'd3;
  localparam logic [15:0] FmtExt  = 16'hFFFE;
  localparam int unsigned QueueDepth = 4;

  // work item passed from front to back
  typedef struct packed {
    logic        is_status;
    logic        is_float;
    logic [1:0]  bps;       // bytes per sample minus one
    logic [31:0] word;      // raw sample bits or rate
    logic [15:0] chans;
    logic [2:0]  status;
  } job_t;

  function automatic logic [7:0] riff_magic(input logic [3:0] pos);
    logic [7:0] m;
    begin
      unique case (pos)
        4'd0: m = 8'h52;
        4'd1: m = 8'h49;
        4'd2: m = 8'h46;
        4'd3: m = 8'h46;
        4'd8: m = 8'h57;
        4'd9: m = 8'h41;
        4'd10: m = 8'h56;
        4'd11: m = 8'h45;
        default: m = 8'h00;
      endcase
      return m;
    end
  endfunction

endpackage

/* rtl/wsp_front.sv */
// byte parser: riff header, chunk walk, fmt fields, sample assembly
`timescale 1ns / 1ps
module wsp_front import wsp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       eof_i,
  output logic       push_o,
  output job_t       job0_o,
  output logic       two_o,
  output job_t       job1_o,
  input  logic [$clog2(Depth+1)-1:0] room_i
);
  localparam int unsigned Cw = $clog2(Depth+1);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic        bad_q, bad_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [32:0] left_q, left_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] dep_q, dep_d;
  logic [31:0] shf_q, shf_d;
  logic [1:0]  idx_q, idx_d;
  logic        seen_q, seen_d;

  logic        acc;
  logic [2:0]  bps;
  logic [31:0] off;
  logic [2:0]  k;
  logic        smp;
  logic [31:0] smp_word;
  logic [2:0]  st;
  logic        pcm_ok, flt_ok;

  // room for two items keeps a beat per cycle
  assign ready_o = (room_i >= Cw'(2));
  assign acc     = valid_i && ready_o;

  always_comb begin
    pcm_ok = (fmt_q == FmtPcm) && (dep_q == 16'd16 || dep_q == 16'd24 || dep_q == 16'd32);
    flt_ok = (fmt_q == FmtFlt) && (dep_q == 16'd32);
    if (pcm_ok) bps = dep_q[5:3];
    else if (flt_ok) bps = 3'd4;
    else bps = 3'd0;
  end

  assign off = len_q - left_q[31:0];
  assign k   = left_q[2:0];

  // next state of the parser
  always_comb begin
    phase_d = phase_q; pos_d = pos_q; bad_d = bad_q; tag_d = tag_q; len_d = len_q;
    left_d = left_q; fmt_d = fmt_q; ch_d = ch_q; rate_d = rate_q; dep_d = dep_q;
    shf_d = shf_q; idx_d = idx_q; seen_d = seen_q;
    smp = 1'b0; smp_word = 32'd0;
    if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;
    unique case (phase_q)
      PH_RIFF: begin
        if (pos_q < 32'd12 && (pos_q < 32'd4 || pos_q >= 32'd8)
            && byte_i != riff_magic(pos_q[3:0])) bad_d = 1'b1;
        if (pos_q >= 32'd11) begin
          phase_d = bad_d ? PH_IDLE : PH_CHDR;
          left_d  = 33'd0;
        end
      end
      PH_CHDR: begin
        if (k < 3'd4) begin
          if (k == 3'd0) tag_d = {24'd0, byte_i};
          else tag_d[8*k[1:0] +: 8] = byte_i;
        end else begin
          if (k == 3'd4) len_d = {24'd0, byte_i};
          else len_d[8*k[1:0] +: 8] = byte_i;
        end
        if (k == 3'd7) begin
          left_d  = {1'b0, len_d};
          idx_d   = 2'd0;
          shf_d   = 32'd0;
          phase_d = (len_d == 32'd0) ? PH_CHDR : PH_BODY;
        end else begin
          left_d = {30'd0, k} + 33'd1;
        end
      end
      PH_BODY: begin
        if (tag_q == TagFmt) begin
          if (len_q >= 32'd16) begin
            priority case (1'b1)
              off == 32'd0: fmt_d = {8'd0, byte_i};
              off == 32'd1: fmt_d[15:8] = byte_i;
              off == 32'd2: ch_d = {8'd0, byte_i};
              off == 32'd3: ch_d[15:8] = byte_i;
              off == 32'd4: rate_d = {24'd0, byte_i};
              off == 32'd5: rate_d[15:8] = byte_i;
              off == 32'd6: rate_d[23:16] = byte_i;
              off == 32'd7: rate_d[31:24] = byte_i;
              off == 32'd14: dep_d = {8'd0, byte_i};
              off == 32'd15: dep_d[15:8] = byte_i;
              off == 32'd24: if (fmt_q == FmtExt && len_q >= 32'd40) shf_d = {24'd0, byte_i};
              off == 32'd25: if (fmt_q == FmtExt && len_q >= 32'd40)
                               fmt_d = {byte_i, shf_q[7:0]};
              default: ;
            endcase
          end
        end else if (tag_q == TagData && bps != 3'd0) begin
          smp_word = shf_q;
          smp_word[8*idx_q +: 8] = byte_i;
          if ({1'b0, idx_q} + 3'd1 >= bps) begin
            smp = 1'b1; idx_d = 2'd0; shf_d = 32'd0;
          end else begin
            shf_d = smp_word; idx_d = idx_q + 2'd1;
          end
        end
        left_d = (left_q != 33'd0) ? left_q - 33'd1 : left_q;
        if (left_d == 33'd0) begin
          if (tag_q == TagData) seen_d = 1'b1;
          phase_d = len_q[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_d = PH_CHDR; left_d = 33'd0;
      end
      default: ;
    endcase
  end

  // final status from updated fields
  always_comb begin
    if (pos_q < 32'd43) st = ST_SMALL;
    else if (bad_d) st = ST_NOT_RIFF;
    else if (ch_d == 16'd0 || rate_d == 32'd0) st = ST_NO_FMT;
    else if (!seen_d) st = ST_NO_DATA;
    else if (fmt_d != FmtPcm && fmt_d != FmtFlt) st = ST_BAD_FMT;
    else if (fmt_d == FmtPcm && dep_d != 16'd16 && dep_d != 16'd24 && dep_d != 16'd32)
      st = ST_BAD_PCM;
    else if (fmt_d == FmtFlt && dep_d != 16'd32) st = ST_BAD_FLOAT;
    else st = ST_OK;
  end

  // items handed to the queue
  always_comb begin
    job0_o = '0; job1_o = '0;
    job1_o.is_status = 1'b1;
    job1_o.word      = rate_d;
    job1_o.chans     = ch_d;
    job1_o.status    = st;
    push_o = 1'b0; two_o = 1'b0;
    if (smp) begin
      job0_o.is_float = (fmt_q == FmtFlt);
      job0_o.bps      = bps[1:0] - 2'd1;
      job0_o.word     = smp_word;
      push_o = acc;
      two_o  = eof_i;
    end else if (eof_i) begin
      job0_o = job1_o;
      push_o = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF; pos_q <= '0; bad_q <= 1'b0; tag_q <= '0; len_q <= '0;
      left_q <= '0; fmt_q <= '0; ch_q <= '0; rate_q <= '0; dep_q <= '0;
      shf_q <= '0; idx_q <= '0; seen_q <= 1'b0;
    end else if (acc) begin
      if (eof_i) begin
        phase_q <= PH_RIFF; pos_q <= '0; bad_q <= 1'b0; tag_q <= '0; len_q <= '0;
        left_q <= '0; fmt_q <= '0; ch_q <= '0; rate_q <= '0; dep_q <= '0;
        shf_q <= '0; idx_q <= '0; seen_q <= 1'b0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; bad_q <= bad_d; tag_q <= tag_d;
        len_q <= len_d; left_q <= left_d; fmt_q <= fmt_d; ch_q <= ch_d;
        rate_q <= rate_d; dep_q <= dep_d; shf_q <= shf_d; idx_q <= idx_d;
        seen_q <= seen_d;
      end
    end
  end

endmodule

/* rtl/wsp_queue.sv */
// short fifo between parser and converter, up to two writes per cycle
`timescale 1ns / 1ps
module wsp_queue import wsp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job0_i,
  input  logic two_i,
  input  job_t job1_i,
  output logic [$clog2(Depth+1)-1:0] room_o,
  output logic empty_o,
  output job_t head_o,
  input  logic pop_i
);
  localparam int unsigned Aw = $clog2(Depth);
  localparam int unsigned Cw = $clog2(Depth+1);

  job_t          mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Cw-1:0] cnt_q;
  logic [Cw-1:0] nin;
  logic          pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign nin     = push_i ? (two_i ? Cw'(2) : Cw'(1)) : '0;
  assign room_o  = Cw'(Depth) - cnt_q;
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job0_i;
      if (two_i) mem_q[Aw'(wr_q + Aw'(1))] <= job1_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= Aw'(wr_q + Aw'(nin));
      if (pop) rd_q <= Aw'(rd_q + Aw'(1));
      cnt_q <= cnt_q + nin - (pop ? Cw'(1) : Cw'(0));
    end
  end

  `include "wav_stream_to_pcm16_top_assert.svh"
  `WSP_ASSERT(a_no_overflow, clk_i, rst_ni, !push_i || (nin <= room_o), "queue overflow")
  `WSP_ASSERT(a_count_range, clk_i, rst_ni, cnt_q <= Cw'(Depth), "count beyond depth")
  `WSP_ASSERT_NEXT(a_pop_nonempty, clk_i, rst_ni, pop && !push_i,
                   cnt_q == $past(cnt_q) - Cw'(1), "pop did not drop count")
endmodule

/* rtl/wsp_back.sv */
// converter: sample word to signed 16 bit, two stages with output register
`timescale 1ns / 1ps
module wsp_back import wsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [67:0] data_o,
  output logic        last_o
);

  // stage 1: float product
  logic        v1_q;
  job_t        j1_q;
  logic [38:0] prod_q;
  logic        adv1, adv2;

  // stage 2: output register
  logic        v2_q;
  logic [67:0] d2_q;
  logic        l2_q;

  logic [15:0] smp;
  logic [7:0]  ex;
  logic [7:0]  n;
  logic [38:0] mag;
  logic        big;

  assign adv2  = !v2_q || ready_i;
  assign adv1  = !v1_q || adv2;
  assign pop_o = adv1 && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= !empty_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      j1_q   <= head_i;
      prod_q <= {15'd0, 1'b1, head_i.word[22:0]} * 39'd32767;
    end
  end

  // float conversion and pcm selection
  always_comb begin
    ex  = j1_q.word[30:23];
    n   = 8'd150 - ex;
    big = (ex >= 8'd150);
    mag = (n >= 8'd39) ? 39'd0 : (prod_q >> n[5:0]);
    if (j1_q.is_float) begin
      if (ex == 8'hFF)
        smp = (j1_q.word[22:0] != 23'd0) ? 16'h0000 :
              (j1_q.word[31] ? 16'h8000 : 16'h7FFF);
      else if (ex == 8'd0) smp = 16'h0000;
      else if (j1_q.word[31])
        smp = (big || mag >= 39'd32768) ? 16'h8000 : 16'(17'h10000 - mag[16:0]);
      else
        smp = (big || mag > 39'd32767) ? 16'h7FFF : mag[15:0];
    end else begin
      unique case (j1_q.bps)
        2'd1: smp = j1_q.word[15:0];
        2'd2: smp = j1_q.word[23:8];
        default: smp = j1_q.word[31:16];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      if (j1_q.is_status) d2_q <= {j1_q.word, j1_q.chans, j1_q.status, 16'd0, 1'b1};
      else d2_q <= {51'd0, smp, 1'b0};
      l2_q <= j1_q.is_status;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = d2_q;
  assign last_o  = l2_q;

  `include "wav_stream_to_pcm16_top_assert.svh"
  `WSP_ASSERT_NEXT(a_hold, clk_i, rst_ni, v2_q && !ready_i, v2_q && $stable(d2_q),
                   "result changed while stalled")
  `WSP_ASSERT(a_last_kind, clk_i, rst_ni, !v2_q || (l2_q == d2_q[0]), "last differs from kind")
  `WSP_ASSERT(a_pop_room, clk_i, rst_ni, !pop_o || adv1, "pop without room")
endmodule

/* rtl/wav_stream_to_pcm16_top.sv */
// top level of the wav stream to pcm16 block
//  channel | dir | tdata fields (low bit up)                               | tlast
//  s_axis  | in  | byte_in[7:0]                                            | end_of_file
//  m_axis  | out | kind, sample[16], status[3], channel_count[16], rate_hz[32] | final_res
// one byte beat per cycle while the queue has room; a byte yields up to two results (sample and status)
// a result goes from the parser through the queue, the multiplier stage and the output register
// a four-entry queue parts parser and converter; input stalls when under two entries free
// reset is asynchronous, active low, and returns the parser to the riff header
`timescale 1ns / 1ps
module wav_stream_to_pcm16_top import wsp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // kind, sample, status, channel_count, rate_hz
  output logic        m_axis_tlast
);
  localparam int unsigned Cw = $clog2(QDepth+1);

  logic          push, two, empty, pop;
  job_t          job0, job1, head;
  logic [Cw-1:0] room;
  logic [67:0]   bdata;

  wsp_front #(.Depth(QDepth)) u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .eof_i(s_axis_tlast), .push_o(push), .job0_o(job0),
    .two_o(two), .job1_o(job1), .room_i(room)
  );

  wsp_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job0_i(job0), .two_i(two), .job1_i(job1),
    .room_o(room), .empty_o(empty), .head_o(head), .pop_i(pop)
  );

  wsp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(bdata), .last_o(m_axis_tlast)
  );

  // pad the packed result to whole bytes
  assign m_axis_tdata = {4'd0, bdata};
endmodule

/* tb/wav_stream_to_pcm16_top_tb.sv */
// testbench for the wav stream to pcm16 block: generated wav files, predicted samples and status
`timescale 1ns / 1ps
module wav_stream_to_pcm16_top_tb;
  import wsp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } wav_beat_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [2:0]  status;
    logic [15:0] chans;
    logic [31:0] rate;
    logic        last;
  } pcm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // byte_in
  logic        s_axis_tlast = 1'b0; // end_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // kind, sample, status, channel_count, rate_hz
  logic        m_axis_tlast;        // final_res

  wav_beat_t   wav_bytes[$];
  wav_beat_t   file_buf[$];
  pcm_result_t expected_q[$];
  int unsigned total_beats, sent_beats, mismatches, cycles;
  logic        beat_taken = 1'b0;

  // predictor state
  logic [31:0] p_pos;
  phase_e      p_phase;
  logic        p_hdr_bad;
  logic [31:0] p_tag, p_clen;
  logic [32:0] p_cleft;
  logic [15:0] p_fcode, p_nch, p_depth;
  logic [31:0] p_rate, p_acc;
  logic [1:0]  p_idx;
  logic        p_got_data;

  wav_stream_to_pcm16_top dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  task automatic clear_parser();
    p_pos = '0; p_phase = PH_RIFF; p_hdr_bad = 1'b0; p_tag = '0; p_clen = '0;
    p_cleft = '0; p_fcode = '0; p_nch = '0; p_rate = '0; p_depth = '0;
    p_acc = '0; p_idx = '0; p_got_data = 1'b0;
  endtask

  function automatic logic [15:0] float_to_pcm16(input logic [31:0] w);
    logic [7:0]  ex;
    logic [63:0] prod, mag;
    int unsigned sh;
    ex = w[30:23];
    if (ex == 8'hFF) return (w[22:0] != 0) ? 16'h0000 : (w[31] ? 16'h8000 : 16'h7FFF);
    if (ex == 8'h00) return 16'h0000;
    if (ex >= 8'd150) begin
      mag = 64'hFFFF_FFFF;
    end else begin
      sh = 150 - ex;
      prod = 64'({1'b1, w[22:0]}) * 64'd32767;
      mag = (sh >= 64) ? 64'd0 : (prod >> sh);
    end
    if (w[31]) return (mag >= 32768) ? 16'h8000 : 16'(17'h10000 - 17'(mag));
    return (mag > 32767) ? 16'h7FFF : mag[15:0];
  endfunction

  function automatic logic [2:0] bytes_per_sample();
    if (p_fcode == FmtPcm && (p_depth == 16 || p_depth == 24 || p_depth == 32))
      return 3'(p_depth / 8);
    if (p_fcode == FmtFlt && p_depth == 32) return 3'd4;
    return 3'd0;
  endfunction

  function automatic status_e file_status();
    if (p_pos < 44) return ST_SMALL;
    if (p_hdr_bad) return ST_NOT_RIFF;
    if (p_nch == 0 || p_rate == 0) return ST_NO_FMT;
    if (!p_got_data) return ST_NO_DATA;
    if (p_fcode != FmtPcm && p_fcode != FmtFlt) return ST_BAD_FMT;
    if (p_fcode == FmtPcm && p_depth != 16 && p_depth != 24 && p_depth != 32)
      return ST_BAD_PCM;
    if (p_fcode == FmtFlt && p_depth != 32) return ST_BAD_FLOAT;
    return ST_OK;
  endfunction

  task automatic take_fmt_byte(input logic [31:0] off, input logic [7:0] b);
    if (p_clen < 16) return;
    case (off)
      0: p_fcode = {8'h00, b};
      1: p_fcode[15:8] = b;
      2: p_nch = {8'h00, b};
      3: p_nch[15:8] = b;
      4: p_rate = {24'h0, b};
      5: p_rate[15:8] = b;
      6: p_rate[23:16] = b;
      7: p_rate[31:24] = b;
      14: p_depth = {8'h00, b};
      15: p_depth[15:8] = b;
      24: if (p_fcode == FmtExt && p_clen >= 40) p_acc = {24'h0, b};
      25: if (p_fcode == FmtExt && p_clen >= 40) p_fcode = {b, p_acc[7:0]};
      default: ;
    endcase
  endtask

  task automatic predict_byte(input wav_beat_t bt);
    logic [31:0]  pos, off;
    logic [2:0]   k, bps;
    logic [15:0]  s;
    pcm_result_t  r;
    pos = p_pos;
    if (p_pos != 32'hFFFF_FFFF) p_pos++;
    case (p_phase)
      PH_RIFF: begin
        if (pos < 12 && (pos < 4 || pos >= 8) && bt.data != riff_magic(pos[3:0]))
          p_hdr_bad = 1'b1;
        if (pos >= 11) begin
          p_phase = p_hdr_bad ? PH_IDLE : PH_CHDR;
          p_cleft = '0;
        end
      end
      PH_CHDR: begin
        k = p_cleft[2:0];
        if (k < 4) begin
          if (k == 0) p_tag = '0;
          p_tag |= 32'(bt.data) << (8 * k);
        end else begin
          if (k == 4) p_clen = '0;
          p_clen |= 32'(bt.data) << (8 * (k - 4));
        end
        if (k == 7) begin
          p_cleft = {1'b0, p_clen};
          p_idx = '0;
          p_acc = '0;
          p_phase = (p_clen == 0) ? PH_CHDR : PH_BODY;
        end else begin
          p_cleft = 33'(k) + 33'd1;
        end
      end
      PH_BODY: begin
        off = p_clen - p_cleft[31:0];
        if (p_tag == TagFmt) begin
          take_fmt_byte(off, bt.data);
        end else if (p_tag == TagData) begin
          bps = bytes_per_sample();
          if (bps != 0) begin
            p_acc |= 32'(bt.data) << (8 * p_idx);
            if (32'(p_idx) + 1 >= bps) begin
              if (p_fcode == FmtFlt) s = float_to_pcm16(p_acc);
              else s = 16'(p_acc >> (8 * (bps - 2)));
              r = '{kind: 1'b0, sample: s, status: '0, chans: '0, rate: '0, last: 1'b0};
              expected_q.push_back(r);
              p_idx = '0;
              p_acc = '0;
            end else begin
              p_idx = p_idx + 2'd1;
            end
          end
        end
        if (p_cleft != 0) p_cleft--;
        if (p_cleft == 0) begin
          if (p_tag == TagData) p_got_data = 1'b1;
          p_phase = p_clen[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        p_phase = PH_CHDR;
        p_cleft = '0;
      end
      default: ;
    endcase
    if (bt.eof) begin
      r = '{kind: 1'b1, sample: '0, status: file_status(), chans: p_nch, rate: p_rate,
            last: 1'b1};
      expected_q.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------- file builder
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_buf.push_back('{data: v[8*i +: 8], eof: 1'b0});
  endtask

  // drops up to cut trailing bytes, then moves the file under construction to the send queue, marking its last byte
  task automatic close_file(input int cut);
    for (int i = 0; i < cut && file_buf.size() > 1; i++) void'(file_buf.pop_back());
    if (file_buf.size() == 0) put_le($urandom, 1);
    file_buf[file_buf.size() - 1].eof = 1'b1;
    foreach (file_buf[i]) wav_bytes.push_back(file_buf[i]);
    file_buf.delete();
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(11))
      0: return 32'h3F80_0000;                       // +1.0
      1: return 32'hBF80_0000;                       // -1.0
      2: return {$urandom_range(1), 8'hFF, 23'h0};   // infinity
      3: return {$urandom_range(1), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))}; // nan
      4: return {$urandom_range(1), 8'h00, 23'($urandom)};                       // denormal
      5: return {$urandom_range(1), 8'($urandom_range(150, 254)), 23'($urandom)};
      default: return {$urandom_range(1), 8'($urandom_range(100, 149)), 23'($urandom)};
    endcase
  endfunction

  // riff header, optional junk chunk, fmt and data chunk
  task automatic build_wav(input logic [15:0] code, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [15:0] depth,
                           input int flen, input int nsamp, input int tail,
                           input bit junk, input bit data_first, input int cut,
                           input bit bad_magic);
    int          bps, dlen, fl;
    logic [15:0] real_code;
    logic [31:0] w;
    put_le(32'h4646_4952, 4);
    put_le($urandom, 4);
    put_le(32'h4556_4157, 4);
    if (bad_magic) begin
      fl = $urandom_range(7);
      if (fl >= 4) fl += 4;
      file_buf[fl].data ^= 8'(1 << $urandom_range(7));
    end
    if (junk) begin
      fl = $urandom_range(1, 5);
      put_le(32'h5453_494C, 4);
      put_le(fl, 4);
      for (int i = 0; i < fl + (fl & 1); i++) put_le($urandom, 1);
    end
    real_code = (code == FmtExt) ? 16'($urandom_range(1) ? FmtFlt : FmtPcm) : code;
    bps = (depth == 16 || depth == 24 || depth == 32) ? depth / 8 : 2;
    dlen = nsamp * bps + tail;
    for (int pass = 0; pass < 2; pass++) begin
      if ((pass == 0) == data_first) begin
        put_le(TagData, 4);
        put_le(dlen, 4);
        for (int i = 0; i < nsamp; i++) begin
          w = (real_code == FmtFlt) ? pick_float() : $urandom;
          put_le(w, bps);
        end
        for (int i = 0; i < tail; i++) put_le($urandom, 1);
        if (dlen & 1) put_le($urandom, 1);
      end else begin
        put_le(TagFmt, 4);
        put_le(flen, 4);
        put_le(code, 2);
        put_le(chans, 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(depth, 2);
        for (int i = 16; i < flen; i++) put_le((i == 24) ? real_code[7:0] :
                                              (i == 25) ? real_code[15:8] : $urandom, 1);
        if (flen & 1) put_le($urandom, 1);
      end
    end
    close_file(cut);
  endtask

  task automatic build_noise(input int len);
    for (int i = 0; i < len; i++) put_le($urandom, 1);
    close_file(0);
  endtask

  task automatic build_random_wav();
    logic [15:0] code, depth;
    int          flen, k;
    k = $urandom_range(9);
    code = (k < 4) ? FmtPcm : (k < 7) ? FmtFlt : (k < 9) ? FmtExt : 16'($urandom);
    k = $urandom_range(9);
    depth = (k < 3) ? 16'd16 : (k < 5) ? 16'd24 : (k < 9) ? 16'd32 : 16'($urandom);
    flen = (code == FmtExt) ? 40 : ($urandom_range(5) == 0 ? $urandom_range(14, 19) : 16);
    build_wav(code, $urandom_range(9) == 0 ? 16'd0 : 16'($urandom_range(1, 8)),
              $urandom_range(9) == 0 ? 32'd0 : $urandom, depth, flen,
              $urandom_range(0, 10), $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0,
              $urandom_range(3) == 0, $urandom_range(7) == 0,
              $urandom_range(7) == 0 ? $urandom_range(1, 12) : 0, $urandom_range(15) == 0);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    beat_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_byte('{data: s_axis_tdata, eof: s_axis_tlast});
      sent_beats++;
    end
  end

  always @(negedge clk_i) begin
    int unsigned send_idle, recv_idle;
    wav_beat_t   bt;
    if (sent_beats < total_beats / 3) begin
      send_idle = 18; recv_idle = 58;
    end else if (sent_beats < 2 * total_beats / 3) begin
      send_idle = 58; recv_idle = 18;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
      // a beat is held until the posedge that takes it
      if (!s_axis_tvalid || beat_taken) begin
        if (wav_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          bt = wav_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= bt.data;
          s_axis_tlast <= bt.eof;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    pcm_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tdata[0], sample: m_axis_tdata[16:1], status: m_axis_tdata[19:17],
              chans: m_axis_tdata[35:20], rate: m_axis_tdata[67:36], last: m_axis_tlast};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d sample %h/%h status %0d/%0d chans %0d/%0d rate %0d/%0d last %0d/%0d (exp/got)",
                     want.kind, got.kind, want.sample, got.sample, want.status, got.status,
                     want.chans, got.chans, want.rate, got.rate, want.last, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    mismatches = 0; sent_beats = 0; cycles = 0;
    clear_parser();
    // directed files: each format and depth, and each failure status
    build_wav(FmtPcm, 2, 44100, 16, 16, 4, 0, 0, 0, 0, 0);
    build_wav(FmtPcm, 1, 48000, 24, 18, 3, 1, 1, 0, 0, 0);
    build_wav(FmtPcm, 16'hFFFF, 32'hFFFF_FFFF, 32, 16, 3, 2, 0, 0, 0, 0);
    build_wav(FmtFlt, 1, 8000, 32, 16, 8, 3, 0, 0, 0, 0);
    build_wav(FmtExt, 2, 96000, 32, 40, 2, 0, 0, 0, 0, 0);
    build_wav(FmtExt, 2, 22050, 16, 40, 3, 1, 0, 0, 0, 0);
    build_wav(FmtPcm, 1, 1000, 16, 16, 2, 0, 0, 1, 0, 0);
    build_wav(FmtPcm, 1, 1000, 16, 16, 6, 0, 0, 0, 5, 0);
    build_wav(FmtPcm, 1, 1000, 16, 16, 2, 0, 0, 0, 0, 1);
    build_wav(FmtPcm, 1, 1000, 16, 14, 2, 0, 0, 0, 0, 0);
    build_wav(16'd2, 1, 1000, 16, 16, 2, 0, 0, 0, 0, 0);
    build_wav(FmtPcm, 1, 1000, 8, 16, 2, 0, 0, 0, 0, 0);
    build_wav(FmtFlt, 1, 1000, 64, 16, 2, 0, 0, 0, 0, 0);
    build_noise(1);
    // random files, mostly well formed
    while (wav_bytes.size() < 650) begin
      if ($urandom_range(7) == 0) build_noise($urandom_range(1, 60));
      else build_random_wav();
    end
    total_beats = wav_bytes.size();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (wav_bytes.size() == 0 && sent_beats == total_beats && expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/wsp_pkg.sv
rtl/wsp_front.sv
rtl/wsp_queue.sv
rtl/wsp_back.sv
rtl/wav_stream_to_pcm16_top.sv
tb/wav_stream_to_pcm16_top_tb.sv
